// File: hw/rtl/gbn_pkg.sv
// gbn_pkg: shared constants, register codes and state type for greedy_box_nms
// depends on nothing; imported by gbn_front, gbn_back, greedy_box_nms and greedy_box_nms_tb

package gbn_pkg;

    localparam int MAX_BOXES_DEF  = 64;
    localparam int COORD_BITS_DEF = 16;
    localparam int CLASS_BITS_DEF = 8;

    localparam int SCORE_BITS    = 17;
    localparam int THR_BITS      = 16;
    localparam int FRAC_BITS     = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [THR_BITS-1:0] THR_RESET = 16'h8000;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_IOU_THRESHOLD = 2'd0,
        REG_IGNORE_CLASS  = 2'd1
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CAND,
        ST_CAND_W,
        ST_KLIST,
        ST_KBOX,
        ST_GEOM,
        ST_MUL_I,
        ST_MUL_A,
        ST_MUL_B,
        ST_UNION,
        ST_PROD_LO,
        ST_PROD_HI,
        ST_CMP,
        ST_KEEP,
        ST_FLUSH
    } t_bk_state;

endpackage

// File: hw/rtl/gbn_front.sv
// gbn_front: takes box words, stores or drops them, hands finished sets to the back end
// depends on gbn_pkg; feeds the box store and job slot used by gbn_back

module gbn_front
    import gbn_pkg::*;
#(
    parameter int MAX_BOXES  = MAX_BOXES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int CLASS_BITS = CLASS_BITS_DEF,
    localparam int IW    = $clog2(MAX_BOXES),
    localparam int CNT_W = $clog2(MAX_BOXES + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_BITS-1:0]  i_box_left,
    input  logic signed [COORD_BITS-1:0]  i_box_top,
    input  logic signed [COORD_BITS-1:0]  i_box_right,
    input  logic signed [COORD_BITS-1:0]  i_box_bottom,
    input  logic signed [SCORE_BITS-1:0]  i_score,
    input  logic        [CLASS_BITS-1:0]  i_class_id,
    input  logic                          i_set_end,
    input  logic                          i_back_busy,
    output logic                          o_wr_en,
    output logic        [IW-1:0]          o_wr_addr,
    output logic        [4*COORD_BITS-1:0] o_wr_corners,
    output logic signed [SCORE_BITS-1:0]  o_wr_score,
    output logic        [CLASS_BITS-1:0]  o_wr_class,
    output logic                          o_job_vld,
    output logic        [CNT_W-1:0]       o_job_cnt,
    output logic                          o_job_ovf,
    input  logic                          i_job_pop
);

    logic             r_cnt_ovf;
    logic [CNT_W-1:0] r_cnt;
    logic             r_job_vld;
    logic [CNT_W-1:0] r_job_cnt;
    logic             r_job_ovf;

    logic             w_accept;
    logic             w_room;
    logic [CNT_W-1:0] w_cnt_after;
    logic             w_ovf_after;

    // a set in flight owns the box store until the back end is done with it
    assign busy     = r_job_vld | i_back_busy;
    assign w_accept = start & ~busy;
    assign w_room   = (r_cnt < CNT_W'(MAX_BOXES));

    assign w_cnt_after = w_room ? r_cnt + CNT_W'(1) : r_cnt;
    assign w_ovf_after = r_cnt_ovf | ~w_room;

    assign o_wr_en      = w_accept & w_room;
    assign o_wr_addr    = r_cnt[IW-1:0];
    assign o_wr_corners = {i_box_left, i_box_top, i_box_right, i_box_bottom};
    assign o_wr_score   = i_score;
    assign o_wr_class   = i_class_id;

    assign o_job_vld = r_job_vld;
    assign o_job_cnt = r_job_cnt;
    assign o_job_ovf = r_job_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_cnt_ovf <= 1'b0;
            r_job_vld <= 1'b0;
        end else begin
            if (i_job_pop) begin
                r_job_vld <= 1'b0;
            end
            if (w_accept) begin
                if (i_set_end) begin
                    r_cnt     <= '0;
                    r_cnt_ovf <= 1'b0;
                    r_job_vld <= 1'b1;
                end else begin
                    r_cnt     <= w_cnt_after;
                    r_cnt_ovf <= w_ovf_after;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_set_end) begin
            r_job_cnt <= w_cnt_after;
            r_job_ovf <= w_ovf_after;
        end
    end

endmodule

// File: hw/rtl/gbn_back.sv
// gbn_back: box store plus the suppression sequencer (ordered pick, overlap test, emit)
// depends on gbn_pkg; fed by gbn_front through its write port and job slot

module gbn_back
    import gbn_pkg::*;
#(
    parameter int MAX_BOXES  = MAX_BOXES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int CLASS_BITS = CLASS_BITS_DEF,
    localparam int IW    = $clog2(MAX_BOXES),
    localparam int CNT_W = $clog2(MAX_BOXES + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic        [IW-1:0]          i_wr_addr,
    input  logic        [4*COORD_BITS-1:0] i_wr_corners,
    input  logic signed [SCORE_BITS-1:0]  i_wr_score,
    input  logic        [CLASS_BITS-1:0]  i_wr_class,
    input  logic                          i_job_vld,
    input  logic        [CNT_W-1:0]       i_job_cnt,
    input  logic                          i_job_ovf,
    output logic                          o_job_pop,
    output logic                          o_busy,
    input  logic        [THR_BITS-1:0]    i_thr,
    input  logic                          i_ign,
    output logic                          o_kept_strobe,
    output logic signed [COORD_BITS-1:0]  o_kept_left,
    output logic signed [COORD_BITS-1:0]  o_kept_top,
    output logic signed [COORD_BITS-1:0]  o_kept_right,
    output logic signed [COORD_BITS-1:0]  o_kept_bottom,
    output logic signed [SCORE_BITS-1:0]  o_kept_score,
    output logic        [CLASS_BITS-1:0]  o_kept_class,
    output logic                          o_final_kept,
    output logic                          o_overflowed
);

    localparam int CB  = COORD_BITS;
    localparam int CW  = COORD_BITS + 1;
    localparam int AW  = 2 * CW;
    localparam int UW  = AW + 1;
    localparam int LH  = (UW + 1) / 2;
    localparam int HH  = UW - LH;
    localparam int PW  = THR_BITS + UW;

    // box store and list of kept indices
    logic        [4*CB-1:0]       mem_corners [MAX_BOXES];
    logic signed [SCORE_BITS-1:0] mem_score   [MAX_BOXES];
    logic        [CLASS_BITS-1:0] mem_class   [MAX_BOXES];
    logic        [IW-1:0]         mem_kept    [MAX_BOXES];

    t_bk_state r_state, n_state;

    logic        [4*CB-1:0]       r_rd_corners;
    logic signed [SCORE_BITS-1:0] r_rd_score;
    logic        [CLASS_BITS-1:0] r_rd_class;
    logic        [IW-1:0]         r_klist_q;

    logic [CNT_W-1:0] r_n;
    logic             r_ovf;
    logic [CNT_W-1:0] r_si;
    logic             r_sv;
    logic [IW-1:0]    r_sidx;
    logic             r_best_vld;
    logic signed [SCORE_BITS-1:0] r_best_score;
    logic [IW-1:0]    r_best_idx;
    logic             r_have_prev;
    logic signed [SCORE_BITS-1:0] r_prev_score;
    logic [IW-1:0]    r_prev_idx;
    logic [CNT_W-1:0] r_kcnt;
    logic [CNT_W-1:0] r_kj;
    logic             r_pend;

    logic [4*CB-1:0]              r_c_corners;
    logic [CLASS_BITS-1:0]        r_c_class;
    logic [4*CB-1:0]              r_p_corners;
    logic signed [SCORE_BITS-1:0] r_p_score;
    logic [CLASS_BITS-1:0]        r_p_class;

    logic signed [CW-1:0] r_iw, r_ih, r_wa, r_ha, r_wb, r_hb;
    logic [AW-1:0]        r_inter, r_area_a, r_area_b;
    logic [UW-1:0]        r_union;
    logic [THR_BITS+LH-1:0] r_plo;
    logic [THR_BITS+HH-1:0] r_phi;

    logic                 r_o_strobe;
    logic [4*CB-1:0]      r_o_corners;
    logic signed [SCORE_BITS-1:0] r_o_score;
    logic [CLASS_BITS-1:0] r_o_class;
    logic                 r_o_final;
    logic                 r_o_ovf;

    // control strobes
    logic          w_scan_issue;
    logic          w_scan_done;
    logic [IW-1:0] w_box_addr;
    logic          w_emit;
    logic          w_enter_scan;
    logic          w_last_kept;

    // scan compare
    logic w_eligible, w_better;

    // geometry
    logic signed [CW-1:0] w_kl, w_kt, w_kr, w_kb, w_cl, w_ct, w_cr, w_cb;
    logic signed [CW-1:0] w_iw, w_ih;
    logic                 w_hit;
    logic signed [CW-1:0] w_ma, w_mb;
    logic signed [AW-1:0] w_mp;
    logic [PW-1:0]        w_lhs, w_rhs;
    logic                 w_suppress;

    assign w_scan_done = (r_si == r_n) && !r_sv;
    assign w_last_kept = (r_kj + CNT_W'(1) == r_kcnt);

    assign w_eligible = !r_have_prev || (r_rd_score < r_prev_score) ||
                        ((r_rd_score == r_prev_score) && (r_sidx > r_prev_idx));
    assign w_better   = !r_best_vld || (r_rd_score > r_best_score);

    // kept box comes from the store read port, candidate from its holding register
    assign w_kl = {r_rd_corners[4*CB-1], r_rd_corners[4*CB-1:3*CB]};
    assign w_kt = {r_rd_corners[3*CB-1], r_rd_corners[3*CB-1:2*CB]};
    assign w_kr = {r_rd_corners[2*CB-1], r_rd_corners[2*CB-1:CB]};
    assign w_kb = {r_rd_corners[CB-1],   r_rd_corners[CB-1:0]};
    assign w_cl = {r_c_corners[4*CB-1],  r_c_corners[4*CB-1:3*CB]};
    assign w_ct = {r_c_corners[3*CB-1],  r_c_corners[3*CB-1:2*CB]};
    assign w_cr = {r_c_corners[2*CB-1],  r_c_corners[2*CB-1:CB]};
    assign w_cb = {r_c_corners[CB-1],    r_c_corners[CB-1:0]};

    assign w_iw = ((w_kr < w_cr) ? w_kr : w_cr) - ((w_kl > w_cl) ? w_kl : w_cl);
    assign w_ih = ((w_kb < w_cb) ? w_kb : w_cb) - ((w_kt > w_ct) ? w_kt : w_ct);
    assign w_hit = (i_ign || (r_rd_class == r_c_class)) &&
                   (w_iw > CW'(0)) && (w_ih > CW'(0));

    // one shared multiplier for the three areas
    always_comb begin
        unique case (r_state)
            ST_MUL_I: begin w_ma = r_iw; w_mb = r_ih; end
            ST_MUL_A: begin w_ma = r_wa; w_mb = r_ha; end
            default:  begin w_ma = r_wb; w_mb = r_hb; end
        endcase
    end
    assign w_mp = w_ma * w_mb;

    assign w_lhs = {{(PW-AW-FRAC_BITS){1'b0}}, r_inter, {FRAC_BITS{1'b0}}};
    assign w_rhs = PW'(r_plo) + (PW'(r_phi) << LH);
    assign w_suppress = (w_lhs > w_rhs);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (i_job_vld) n_state = ST_SCAN;
            ST_SCAN:    if (w_scan_done) n_state = r_best_vld ? ST_CAND : ST_FLUSH;
            ST_CAND:    n_state = ST_CAND_W;
            ST_CAND_W:  n_state = (r_kcnt == '0) ? ST_KEEP : ST_KLIST;
            ST_KLIST:   n_state = ST_KBOX;
            ST_KBOX:    n_state = ST_GEOM;
            ST_GEOM: begin
                if (w_hit)            n_state = ST_MUL_I;
                else if (w_last_kept) n_state = ST_KEEP;
                else                  n_state = ST_KLIST;
            end
            ST_MUL_I:   n_state = ST_MUL_A;
            ST_MUL_A:   n_state = ST_MUL_B;
            ST_MUL_B:   n_state = ST_UNION;
            ST_UNION:   n_state = ST_PROD_LO;
            ST_PROD_LO: n_state = ST_PROD_HI;
            ST_PROD_HI: n_state = ST_CMP;
            ST_CMP: begin
                if (w_suppress)       n_state = ST_SCAN;
                else if (w_last_kept) n_state = ST_KEEP;
                else                  n_state = ST_KLIST;
            end
            ST_KEEP:    n_state = ST_SCAN;
            ST_FLUSH:   n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_busy       = (r_state != ST_IDLE);
        o_job_pop    = (r_state == ST_IDLE) && i_job_vld;
        w_scan_issue = (r_state == ST_SCAN) && (r_si != r_n);
        w_box_addr   = (r_state == ST_CAND) ? r_best_idx : r_klist_q;
        w_emit       = ((r_state == ST_KEEP) && r_pend) || (r_state == ST_FLUSH);
        w_enter_scan = (n_state == ST_SCAN) && (r_state != ST_SCAN);
    end

    // store writes and registered reads
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_corners[i_wr_addr] <= i_wr_corners;
            mem_score[i_wr_addr]   <= i_wr_score;
            mem_class[i_wr_addr]   <= i_wr_class;
        end
        if (r_state == ST_KEEP) begin
            mem_kept[r_kcnt[IW-1:0]] <= r_best_idx;
        end
        r_rd_score   <= mem_score[r_si[IW-1:0]];
        r_rd_corners <= mem_corners[w_box_addr];
        r_rd_class   <= mem_class[w_box_addr];
        r_klist_q    <= mem_kept[r_kj[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sv        <= 1'b0;
            r_best_vld  <= 1'b0;
            r_have_prev <= 1'b0;
            r_pend      <= 1'b0;
            r_o_strobe  <= 1'b0;
            r_si        <= '0;
            r_kcnt      <= '0;
            r_kj        <= '0;
        end else begin
            r_state    <= n_state;
            r_o_strobe <= w_emit;
            r_sv       <= w_scan_issue;

            if (o_job_pop) begin
                r_kcnt      <= '0;
                r_pend      <= 1'b0;
                r_have_prev <= 1'b0;
            end

            if (w_enter_scan) begin
                r_si       <= '0;
                r_best_vld <= 1'b0;
                // leaving a candidate: the next pick must come after it
                if (r_state != ST_IDLE) begin
                    r_have_prev <= 1'b1;
                end
            end else if (w_scan_issue) begin
                r_si <= r_si + CNT_W'(1);
            end

            if ((r_state == ST_SCAN) && r_sv && w_eligible && w_better) begin
                r_best_vld <= 1'b1;
            end

            if (r_state == ST_CAND_W) begin
                r_kj <= '0;
            end else if (((r_state == ST_GEOM) && !w_hit) ||
                         ((r_state == ST_CMP) && !w_suppress)) begin
                r_kj <= r_kj + CNT_W'(1);
            end

            if (r_state == ST_KEEP) begin
                r_kcnt <= r_kcnt + CNT_W'(1);
                r_pend <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_n   <= i_job_cnt;
            r_ovf <= i_job_ovf;
        end
        r_sidx <= r_si[IW-1:0];
        if ((r_state == ST_SCAN) && r_sv && w_eligible && w_better) begin
            r_best_score <= r_rd_score;
            r_best_idx   <= r_sidx;
        end
        if (w_enter_scan) begin
            r_prev_score <= r_best_score;
            r_prev_idx   <= r_best_idx;
        end
        if (r_state == ST_CAND_W) begin
            r_c_corners <= r_rd_corners;
            r_c_class   <= r_rd_class;
        end
        if (r_state == ST_GEOM) begin
            r_iw <= w_iw;
            r_ih <= w_ih;
            r_wa <= w_kr - w_kl;
            r_ha <= w_kb - w_kt;
            r_wb <= w_cr - w_cl;
            r_hb <= w_cb - w_ct;
        end
        unique case (r_state)
            ST_MUL_I: r_inter  <= w_mp;
            ST_MUL_A: r_area_a <= w_mp;
            ST_MUL_B: r_area_b <= w_mp;
            default: ;
        endcase
        if (r_state == ST_UNION) begin
            r_union <= UW'(r_area_a) + UW'(r_area_b) - UW'(r_inter);
        end
        if (r_state == ST_PROD_LO) begin
            r_plo <= (THR_BITS+LH)'(i_thr) * (THR_BITS+LH)'(r_union[LH-1:0]);
        end
        if (r_state == ST_PROD_HI) begin
            r_phi <= (THR_BITS+HH)'(i_thr) * (THR_BITS+HH)'(r_union[UW-1:LH]);
        end
        if (r_state == ST_KEEP) begin
            r_p_corners <= r_c_corners;
            r_p_score   <= r_best_score;
            r_p_class   <= r_c_class;
        end
        // result held back one kept box so the final mark is known
        if (w_emit) begin
            r_o_corners <= r_p_corners;
            r_o_score   <= r_p_score;
            r_o_class   <= r_p_class;
            r_o_final   <= (r_state == ST_FLUSH);
            r_o_ovf     <= r_ovf;
        end
    end

    assign o_kept_strobe = r_o_strobe;
    assign o_kept_left   = r_o_corners[4*CB-1:3*CB];
    assign o_kept_top    = r_o_corners[3*CB-1:2*CB];
    assign o_kept_right  = r_o_corners[2*CB-1:CB];
    assign o_kept_bottom = r_o_corners[CB-1:0];
    assign o_kept_score  = r_o_score;
    assign o_kept_class  = r_o_class;
    assign o_final_kept  = r_o_final;
    assign o_overflowed  = r_o_ovf;

endmodule

// File: hw/rtl/greedy_box_nms.sv
// greedy_box_nms: top level, configuration registers and the front/back pair
// depends on gbn_pkg, gbn_front and gbn_back
//
// usage: boxes are presented on the i_box_* / i_score / i_class_id ports and taken
// at an edge where start is high and busy is low, one box per cycle while a set loads.
// the box carrying i_set_end closes the set; busy then stays high while the set is
// suppressed and the kept boxes are sent; the final kept box appears in the cycle
// in which busy falls.
// results: each kept box appears for one cycle with o_kept_strobe high, in descending
// score order (ties in arrival order); o_final_kept marks the last one and
// o_overflowed is high on every result of a set that lost boxes past capacity.
// the receiver cannot stall; results are never held.
// sequence: each visited box costs an ordered-pick scan in the score store, a fetch,
// and, for each kept box it is tested against, store reads, three area products and
// two threshold products; a box that is kept is written to the kept list.
// configuration: i_cfg_valid/o_cfg_ready write word, index 0 threshold, 1 class
// ignore; o_cfg_ready is always high, writes are meant for idle periods.
// reset: synchronous active-low i_rst_n empties the store and restores the
// registers (threshold 0.5, classes compared).

module greedy_box_nms
    import gbn_pkg::*;
#(
    parameter int MAX_BOXES  = MAX_BOXES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int CLASS_BITS = CLASS_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_BITS-1:0]  i_box_left,
    input  logic signed [COORD_BITS-1:0]  i_box_top,
    input  logic signed [COORD_BITS-1:0]  i_box_right,
    input  logic signed [COORD_BITS-1:0]  i_box_bottom,
    input  logic signed [SCORE_BITS-1:0]  i_score,
    input  logic        [CLASS_BITS-1:0]  i_class_id,
    input  logic                          i_set_end,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic        [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic        [CFG_DATA_BITS-1:0] i_cfg_data,
    output logic                          o_kept_strobe,
    output logic signed [COORD_BITS-1:0]  o_kept_left,
    output logic signed [COORD_BITS-1:0]  o_kept_top,
    output logic signed [COORD_BITS-1:0]  o_kept_right,
    output logic signed [COORD_BITS-1:0]  o_kept_bottom,
    output logic signed [SCORE_BITS-1:0]  o_kept_score,
    output logic        [CLASS_BITS-1:0]  o_kept_class,
    output logic                          o_final_kept,
    output logic                          o_overflowed
);

    localparam int IW    = $clog2(MAX_BOXES);
    localparam int CNT_W = $clog2(MAX_BOXES + 1);

    logic [THR_BITS-1:0] r_thr;
    logic                r_ign;

    logic                    w_wr_en;
    logic [IW-1:0]           w_wr_addr;
    logic [4*COORD_BITS-1:0] w_wr_corners;
    logic signed [SCORE_BITS-1:0] w_wr_score;
    logic [CLASS_BITS-1:0]   w_wr_class;
    logic                    w_job_vld;
    logic [CNT_W-1:0]        w_job_cnt;
    logic                    w_job_ovf;
    logic                    w_job_pop;
    logic                    w_back_busy;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
            r_ign <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_IOU_THRESHOLD) begin
                r_thr <= i_cfg_data[THR_BITS-1:0];
            end else if (i_cfg_index == REG_IGNORE_CLASS) begin
                r_ign <= i_cfg_data[0];
            end
        end
    end

    gbn_front #(
        .MAX_BOXES  (MAX_BOXES),
        .COORD_BITS (COORD_BITS),
        .CLASS_BITS (CLASS_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_box_left   (i_box_left),
        .i_box_top    (i_box_top),
        .i_box_right  (i_box_right),
        .i_box_bottom (i_box_bottom),
        .i_score      (i_score),
        .i_class_id   (i_class_id),
        .i_set_end    (i_set_end),
        .i_back_busy  (w_back_busy),
        .o_wr_en      (w_wr_en),
        .o_wr_addr    (w_wr_addr),
        .o_wr_corners (w_wr_corners),
        .o_wr_score   (w_wr_score),
        .o_wr_class   (w_wr_class),
        .o_job_vld    (w_job_vld),
        .o_job_cnt    (w_job_cnt),
        .o_job_ovf    (w_job_ovf),
        .i_job_pop    (w_job_pop)
    );

    gbn_back #(
        .MAX_BOXES  (MAX_BOXES),
        .COORD_BITS (COORD_BITS),
        .CLASS_BITS (CLASS_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr_en       (w_wr_en),
        .i_wr_addr     (w_wr_addr),
        .i_wr_corners  (w_wr_corners),
        .i_wr_score    (w_wr_score),
        .i_wr_class    (w_wr_class),
        .i_job_vld     (w_job_vld),
        .i_job_cnt     (w_job_cnt),
        .i_job_ovf     (w_job_ovf),
        .o_job_pop     (w_job_pop),
        .o_busy        (w_back_busy),
        .i_thr         (r_thr),
        .i_ign         (r_ign),
        .o_kept_strobe (o_kept_strobe),
        .o_kept_left   (o_kept_left),
        .o_kept_top    (o_kept_top),
        .o_kept_right  (o_kept_right),
        .o_kept_bottom (o_kept_bottom),
        .o_kept_score  (o_kept_score),
        .o_kept_class  (o_kept_class),
        .o_final_kept  (o_final_kept),
        .o_overflowed  (o_overflowed)
    );

endmodule

// File: tb/greedy_box_nms_tb.sv
// greedy_box_nms_tb: self-checking bench for greedy box suppression with a local predictor
// depends on gbn_pkg and greedy_box_nms; boxes fed from a queue, kept boxes checked in order

module greedy_box_nms_tb;
    import gbn_pkg::*;

    localparam int NBOX = 64;

    typedef struct {
        logic signed [15:0] left, top, right, bottom;
        logic signed [16:0] score;
        logic [7:0]         cls;
        logic               last;
    } box_t;

    typedef struct {
        logic signed [15:0] left, top, right, bottom;
        logic signed [16:0] score;
        logic [7:0]         cls;
        logic               fin, ovf;
    } kept_t;

    logic i_clk = 0, i_rst_n = 0, start = 0, busy;
    logic signed [15:0] i_box_left = 0, i_box_top = 0, i_box_right = 0, i_box_bottom = 0;
    logic signed [16:0] i_score = 0;
    logic [7:0] i_class_id = 0;
    logic i_set_end = 0, i_cfg_valid = 0, o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = REG_IOU_THRESHOLD;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = 0;
    logic o_kept_strobe, o_final_kept, o_overflowed;
    logic signed [15:0] o_kept_left, o_kept_top, o_kept_right, o_kept_bottom;
    logic signed [16:0] o_kept_score;
    logic [7:0] o_kept_class;

    greedy_box_nms dut (.*);

    box_t  pending_q[$];
    kept_t kept_q[$];
    box_t  cur_box;
    int    errors = 0;
    int    gap_left = 0;
    bit    no_idle = 0;

    // predictor copy of block state
    logic [15:0] thr_reg = THR_RESET;
    logic        ign_reg = 0;
    box_t        store[NBOX];
    int          n_stored = 0;
    bit          dropped = 0;

    initial forever #10 i_clk = ~i_clk;

    task automatic report(string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic void queue_box(box_t b);
        pending_q.insert(pending_q.size(), b);
    endfunction

    function automatic bit too_close(box_t p, box_t q);
        longint iw, ih, a1, a2, inter, uni;
        if (!ign_reg && p.cls != q.cls) return 0;
        iw = (p.right < q.right ? p.right : q.right) - (p.left > q.left ? p.left : q.left);
        ih = (p.bottom < q.bottom ? p.bottom : q.bottom) - (p.top > q.top ? p.top : q.top);
        if (iw <= 0 || ih <= 0) return 0;
        a1 = (longint'(p.right) - p.left) * (longint'(p.bottom) - p.top);
        a2 = (longint'(q.right) - q.left) * (longint'(q.bottom) - q.top);
        inter = iw * ih;
        uni = a1 + a2 - inter;
        return (inter * 65536) > (longint'(thr_reg) * uni);
    endfunction

    // store the box and, on set end, predict the kept list
    function automatic void load_box(box_t b);
        int order[$];
        int kept[$];
        int j;
        bit keep;
        kept_t r;
        if (n_stored < NBOX) begin
            store[n_stored] = b;
            n_stored++;
        end else begin
            dropped = 1;
        end
        if (!b.last) return;
        for (int i = 0; i < n_stored; i++) begin
            j = 0;
            while (j < order.size() && store[order[j]].score >= store[i].score) j++;
            order.insert(j, i);
        end
        foreach (order[i]) begin
            keep = 1;
            foreach (kept[k]) if (too_close(store[kept[k]], store[order[i]])) keep = 0;
            if (keep) kept.insert(kept.size(), order[i]);
        end
        foreach (kept[i]) begin
            r.left = store[kept[i]].left;   r.top = store[kept[i]].top;
            r.right = store[kept[i]].right; r.bottom = store[kept[i]].bottom;
            r.score = store[kept[i]].score; r.cls = store[kept[i]].cls;
            r.fin = (i == kept.size() - 1); r.ovf = dropped;
            kept_q.insert(kept_q.size(), r);
        end
        n_stored = 0;
        dropped = 0;
    endfunction

    function automatic int pick_gap();
        if (no_idle) return 0;
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
        return $urandom_range(5, 40);
    endfunction

    // driver: accept on rising edge, change inputs on falling edge
    bit taken = 0;
    always @(posedge i_clk) begin
        taken = 0;
        if (i_rst_n && start && !busy) begin
            taken = 1;
            load_box(cur_box);
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (taken || !start)) begin
            if (taken) gap_left = pick_gap();
            if (gap_left > 0 || pending_q.size() == 0) begin
                start <= 0;
                if (gap_left > 0) gap_left--;
            end else begin
                cur_box = pending_q.pop_front();
                i_box_left <= cur_box.left;   i_box_top <= cur_box.top;
                i_box_right <= cur_box.right; i_box_bottom <= cur_box.bottom;
                i_score <= cur_box.score;     i_class_id <= cur_box.cls;
                i_set_end <= cur_box.last;
                start <= 1;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        kept_t e;
        if (i_rst_n && o_kept_strobe) begin
            if (kept_q.size() == 0) begin
                report("kept word with nothing expected");
            end else begin
                e = kept_q.pop_front();
                if (o_kept_left !== e.left || o_kept_top !== e.top ||
                    o_kept_right !== e.right || o_kept_bottom !== e.bottom)
                    report($sformatf("corners %0d %0d %0d %0d exp %0d %0d %0d %0d",
                        o_kept_left, o_kept_top, o_kept_right, o_kept_bottom,
                        e.left, e.top, e.right, e.bottom));
                if (o_kept_score !== e.score)
                    report($sformatf("score %0d exp %0d", o_kept_score, e.score));
                if (o_kept_class !== e.cls)
                    report($sformatf("class %0d exp %0d", o_kept_class, e.cls));
                if (o_final_kept !== e.fin)
                    report($sformatf("final %0b exp %0b", o_final_kept, e.fin));
                if (o_overflowed !== e.ovf)
                    report($sformatf("overflow %0b exp %0b", o_overflowed, e.ovf));
            end
        end
    end

    function automatic box_t mk(int l, int t, int r, int b, int sc, int c, bit last);
        box_t x;
        x.left = 16'(l); x.top = 16'(t); x.right = 16'(r); x.bottom = 16'(b);
        x.score = 17'(sc); x.cls = 8'(c); x.last = last;
        return x;
    endfunction

    // random set: mostly clustered boxes so suppression matters, some full-range noise
    task automatic add_set(int n);
        int cx, cy, w, h, sc;
        cx = $urandom_range(0, 60000) - 30000;
        cy = $urandom_range(0, 60000) - 30000;
        sc = $urandom_range(0, 131071) - 65536;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                queue_box(mk($urandom_range(0, 65535) - 32768,
                    $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                    $urandom_range(0, 65535) - 32768, $urandom_range(0, 131071) - 65536,
                    $urandom_range(0, 255), i == n - 1));
            end else begin
                w = $urandom_range(1, 300);
                h = $urandom_range(1, 300);
                if ($urandom_range(0, 3) != 0) sc = $urandom_range(0, 131071) - 65536;
                queue_box(mk(cx + $urandom_range(0, 60) - 30,
                    cy + $urandom_range(0, 60) - 30,
                    cx + w, cy + h, sc, $urandom_range(0, 2), i == n - 1));
            end
        end
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_q.size() != 0 || start || kept_q.size() != 0 || busy);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_reg_idx idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_IOU_THRESHOLD) thr_reg = val;
        else ign_reg = val[0];
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    initial begin
        int total;
        total = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: extremes, ties, inverted, disjoint, class split, single box
        queue_box(mk(-32768, -32768, 32767, 32767, 65535, 255, 0));
        queue_box(mk(-32768, -32768, 32767, 32767, -65536, 255, 0));
        queue_box(mk(0, 0, 100, 100, 100, 0, 0));
        queue_box(mk(0, 0, 100, 100, 100, 1, 0));
        queue_box(mk(10, 10, 100, 100, 100, 0, 0));
        queue_box(mk(100, 0, 0, 100, 200, 0, 0));
        queue_box(mk(100, 0, 200, 100, 50, 0, 0));
        queue_box(mk(0, 0, 100, 100, 0, 0, 1));
        queue_box(mk(32767, 32767, -32768, -32768, -65536, 0, 1));
        total += 9;
        wait_idle();
        cfg_write(REG_IOU_THRESHOLD, 16'h0000);
        cfg_write(REG_IGNORE_CLASS, 16'd1);
        queue_box(mk(0, 0, 10, 10, 5, 3, 0));
        queue_box(mk(9, 9, 20, 20, 5, 4, 0));
        queue_box(mk(10, 0, 20, 10, 7, 3, 1));
        total += 3;
        wait_idle();
        cfg_write(REG_IOU_THRESHOLD, 16'hFFFF);
        cfg_write(REG_IGNORE_CLASS, 16'd0);
        queue_box(mk(0, 0, 10, 10, 5, 3, 0));
        queue_box(mk(0, 0, 10, 10, 5, 3, 1));
        total += 2;

        // random phases with several settings
        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            no_idle = (ph % 3 == 1);
            case (ph)
                0: cfg_write(REG_IOU_THRESHOLD, 16'h0000);
                1: cfg_write(REG_IOU_THRESHOLD, 16'hFFFF);
                default: cfg_write(REG_IOU_THRESHOLD, 16'($urandom_range(0, 65535)));
            endcase
            cfg_write(REG_IGNORE_CLASS, 16'($urandom_range(0, 1)));
            if (ph == 2 || ph == 6) begin
                // store full: boxes past capacity are dropped
                add_set(NBOX + 2 + ph / 3);
                total += NBOX + 2 + ph / 3;
            end
            repeat (5) begin
                int n;
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 24)
                                                : $urandom_range(1, 8);
                add_set(n);
                total += n;
            end
            if (total >= 360 && ph >= 6) break;
        end
        wait_idle();
        repeat (100) @(posedge i_clk);
        if (errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #80000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: greedy_box_nms.f
hw/rtl/gbn_pkg.sv
hw/rtl/gbn_front.sv
hw/rtl/gbn_back.sv
hw/rtl/greedy_box_nms.sv
tb/greedy_box_nms_tb.sv
